>>> src/crs_pkg.sv
package crs_pkg;

    localparam int NUM_LINES_DEF = 5;
    localparam int NUM_CODED     = 5;
    localparam int LINE_W        = 3;
    localparam int PRIO_W        = 8;
    localparam int UPPER_W       = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 8;

    localparam logic [1:0] ST_DOWN    = 2'd0;
    localparam logic [1:0] ST_STANDBY = 2'd1;
    localparam logic [1:0] ST_ACTIVE  = 2'd2;

    localparam logic [1:0] CMD_LINK_DOWN = 2'd0;
    localparam logic [1:0] CMD_LINK_UP   = 2'd1;
    localparam logic [1:0] CMD_MANUAL    = 2'd2;
    localparam logic [1:0] CMD_CHECK     = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_LINE  = 2'd1;
    localparam logic [1:0] STAT_NO_SOURCE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROTECTED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_GPSA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_GPSB = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_EXTF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_CLKA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_CLKB = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MUX_UPPER = 3'd6;

    localparam logic [PRIO_W-1:0] PRIO_NEVER = 8'hFF;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic apply;
        logic report;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
    } dp_stat_t;

    // Source select code driven onto the clock mux for each coded line
    function automatic logic [2:0] mux_code_of(input logic [LINE_W-1:0] idx);
        logic [2:0] code;
        unique case (idx)
            3'd0:    code = 3'b000;
            3'd1:    code = 3'b001;
            3'd2:    code = 3'b100;
            3'd3:    code = 3'b010;
            3'd4:    code = 3'b011;
            default: code = 3'b000;
        endcase
        return code;
    endfunction

endpackage

>>> src/clock_reference_selector.sv
// Clock reference selector: picks which clock reference line drives the clock mux.
//
// Event channel: an event (cmd, line) transfers at a rising edge with start high
// and busy low. busy stays high while the event is worked on.
// Result channel: done is high for exactly one cycle with status, active_line,
// mux_value, mux_written, holdover and primary_ref_active valid in that cycle.
// The receiver cannot stall; a result must be taken in its done cycle.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data; the
// indexed register, if mapped, is written on each transfer. cfg_ready is always
// high. Write only while busy is low and no result is pending.
//
// Sequence: after the accepting edge the best-standby search walks one line per
// cycle, an apply step then updates the line state and a report step loads the
// result registers; done rises with that load and busy falls with it, so a new
// event is taken only once the previous result is out. The walk over the line
// states takes most of the time per event.
//
// Reset (rst_n low, asynchronous): all lines down, no links up, active line 0,
// mux register 0, protected mode on, all priorities 255, mux upper bits 0.
module clock_reference_selector #(
    parameter int NUM_LINES = crs_pkg::NUM_LINES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       cmd,
    input  logic [crs_pkg::LINE_W-1:0]       line,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [crs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [crs_pkg::LINE_W-1:0]       active_line,
    output logic [7:0]                       mux_value,
    output logic                             mux_written,
    output logic                             holdover,
    output logic                             primary_ref_active
);
    import crs_pkg::*;

    // configuration held for the datapath
    logic                             protected_mode;
    logic [NUM_CODED-1:0][PRIO_W-1:0] prio;
    logic [UPPER_W-1:0]               mux_upper;

    // controller to datapath commands and returned status
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    crs_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .protected_mode (protected_mode),
        .prio           (prio),
        .mux_upper      (mux_upper)
    );

    // sequence each event: capture, search, apply, report
    crs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .done    (done),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat)
    );

    // line state, link flags, active line, mux register and the standby search
    crs_dp #(
        .NUM_LINES (NUM_LINES)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .dp_cmd             (dp_cmd),
        .dp_stat            (dp_stat),
        .cmd                (cmd),
        .line               (line),
        .protected_mode     (protected_mode),
        .prio               (prio),
        .mux_upper          (mux_upper),
        .status             (status),
        .active_line        (active_line),
        .mux_value          (mux_value),
        .mux_written        (mux_written),
        .holdover           (holdover),
        .primary_ref_active (primary_ref_active)
    );

endmodule

>>> src/crs_cfg.sv
module crs_cfg (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [crs_pkg::CFG_IDX_W-1:0]                 cfg_index,
    input  logic [crs_pkg::CFG_DATA_W-1:0]                cfg_data,
    output logic                                          protected_mode,
    output logic [crs_pkg::NUM_CODED-1:0][crs_pkg::PRIO_W-1:0] prio,
    output logic [crs_pkg::UPPER_W-1:0]                   mux_upper
);
    import crs_pkg::*;

    logic                               prot_reg;
    logic [NUM_CODED-1:0][PRIO_W-1:0]   prio_reg;
    logic [UPPER_W-1:0]                 upper_reg;

    assign cfg_ready      = 1'b1;
    assign protected_mode = prot_reg;
    assign prio           = prio_reg;
    assign mux_upper      = upper_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prot_reg  <= 1'b1;
            prio_reg  <= {NUM_CODED{PRIO_NEVER}};
            upper_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // drop writes to unmapped indices
            unique case (cfg_index)
                CFG_PROTECTED: prot_reg    <= cfg_data[0];
                CFG_PRIO_GPSA: prio_reg[0] <= cfg_data;
                CFG_PRIO_GPSB: prio_reg[1] <= cfg_data;
                CFG_PRIO_EXTF: prio_reg[2] <= cfg_data;
                CFG_PRIO_CLKA: prio_reg[3] <= cfg_data;
                CFG_PRIO_CLKB: prio_reg[4] <= cfg_data;
                CFG_MUX_UPPER: upper_reg   <= cfg_data[UPPER_W-1:0];
                default:       ;
            endcase
        end
    end

endmodule

>>> src/crs_ctrl.sv
module crs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output crs_pkg::dp_cmd_t  dp_cmd,
    input  crs_pkg::dp_stat_t dp_stat
);
    import crs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_REPORT
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    assign busy = busy_reg;
    assign done = done_reg;

    always_comb
    begin
        dp_cmd.capture   = (state_reg == S_IDLE) && start;
        dp_cmd.scan_step = (state_reg == S_SCAN);
        dp_cmd.apply     = (state_reg == S_APPLY);
        dp_cmd.report    = (state_reg == S_REPORT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            // strobe done from the report state, rising as the result registers load
            done_reg <= (state_reg == S_REPORT);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_SCAN;
                        busy_reg  <= 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (dp_stat.scan_last)
                        state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    state_reg <= S_REPORT;
                end
                S_REPORT:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/crs_dp.sv
module crs_dp #(
    parameter int NUM_LINES = crs_pkg::NUM_LINES_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  crs_pkg::dp_cmd_t                              dp_cmd,
    output crs_pkg::dp_stat_t                             dp_stat,
    input  logic [1:0]                                    cmd,
    input  logic [crs_pkg::LINE_W-1:0]                    line,
    input  logic                                          protected_mode,
    input  logic [crs_pkg::NUM_CODED-1:0][crs_pkg::PRIO_W-1:0] prio,
    input  logic [crs_pkg::UPPER_W-1:0]                   mux_upper,
    output logic [1:0]                                    status,
    output logic [crs_pkg::LINE_W-1:0]                    active_line,
    output logic [7:0]                                    mux_value,
    output logic                                          mux_written,
    output logic                                          holdover,
    output logic                                          primary_ref_active
);
    import crs_pkg::*;

    localparam int IDX_W = $clog2(NUM_LINES);

    // per-line priority; lines without a mux code are never chosen
    logic [PRIO_W-1:0] prio_line [NUM_LINES];

    for (genvar g = 0; g < NUM_LINES; g++)
    begin : g_prio
        if (g < NUM_CODED)
        begin : g_coded
            assign prio_line[g] = prio[g];
        end
        else
        begin : g_uncoded
            assign prio_line[g] = PRIO_NEVER;
        end
    end

    logic [1:0]        ls_reg [NUM_LINES];
    logic [1:0]        ls_next [NUM_LINES];
    logic              lu_reg [NUM_LINES];
    logic              lu_next [NUM_LINES];
    logic [IDX_W-1:0]  act_reg;
    logic [IDX_W-1:0]  act_next;
    logic [7:0]        mux_reg;
    logic [7:0]        mux_next;

    logic [1:0]        cmd_reg;
    logic [LINE_W-1:0] line_reg;

    logic [IDX_W-1:0]  cnt_reg;
    logic              best_found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [PRIO_W-1:0] best_p_reg;

    logic [1:0]        stat_reg;
    logic [1:0]        stat_next;
    logic              wr_reg;
    logic              wr_next;

    logic [1:0]        status_reg;
    logic [LINE_W-1:0] active_line_reg;
    logic [7:0]        mux_value_reg;
    logic              mux_written_reg;
    logic              holdover_reg;
    logic              primary_reg;

    logic [IDX_W-1:0]  li;
    logic              line_ok;
    logic              scan_hit;
    logic              hold_now;

    assign li      = line_reg[IDX_W-1:0];
    assign line_ok = {1'b0, line_reg} < (LINE_W+1)'(NUM_LINES);

    assign dp_stat.scan_last = (cnt_reg == IDX_W'(NUM_LINES - 1));

    // a link-down line counts as down for the standby search
    assign scan_hit = (ls_reg[cnt_reg] == ST_STANDBY)
                   && !((cmd_reg == CMD_LINK_DOWN) && (cnt_reg == li))
                   && (prio_line[cnt_reg] < best_p_reg);

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg        <= cmd;
            line_reg       <= line;
            cnt_reg        <= '0;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_p_reg     <= PRIO_NEVER;
        end
        else if (dp_cmd.scan_step)
        begin
            if (!dp_stat.scan_last)
                cnt_reg <= cnt_reg + 1'b1;
            if (scan_hit)
            begin
                best_found_reg <= 1'b1;
                best_idx_reg   <= cnt_reg;
                best_p_reg     <= prio_line[cnt_reg];
            end
        end
    end

    function automatic logic has_code(input logic [IDX_W-1:0] idx);
        return LINE_W'(idx) < LINE_W'(NUM_CODED);
    endfunction

    function automatic logic [7:0] mux_word(input logic [UPPER_W-1:0] upper,
                                            input logic [IDX_W-1:0] idx);
        return {upper, mux_code_of(LINE_W'(idx))};
    endfunction

    always_comb
    begin
        logic act_active;
        ls_next   = ls_reg;
        lu_next   = lu_reg;
        act_next  = act_reg;
        mux_next  = mux_reg;
        stat_next = STAT_OK;
        wr_next   = 1'b0;
        act_active = 1'b0;

        if ((cmd_reg != CMD_CHECK) && !line_ok)
        begin
            stat_next = STAT_BAD_LINE;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_LINK_DOWN:
                begin
                    lu_next[li] = 1'b0;
                    if (protected_mode || (act_reg != li))
                    begin
                        ls_next[li] = ST_DOWN;
                        if (act_reg == li)
                        begin
                            if (!best_found_reg)
                                stat_next = STAT_NO_SOURCE;
                            else if (!has_code(best_idx_reg))
                                stat_next = STAT_BAD_LINE;
                            else
                            begin
                                wr_next               = 1'b1;
                                mux_next              = mux_word(mux_upper, best_idx_reg);
                                act_next              = best_idx_reg;
                                ls_next[best_idx_reg] = ST_ACTIVE;
                            end
                        end
                    end
                end
                CMD_LINK_UP:
                begin
                    lu_next[li] = 1'b1;
                    if (!protected_mode)
                    begin
                        if (act_reg != li)
                            ls_next[li] = ST_STANDBY;
                    end
                    else
                    begin
                        ls_next[li] = ST_STANDBY;
                        act_active  = (act_reg != li) && (ls_reg[act_reg] == ST_ACTIVE);
                        if (!act_active || (prio_line[li] < prio_line[act_reg]))
                        begin
                            if (has_code(li))
                            begin
                                wr_next  = 1'b1;
                                mux_next = mux_word(mux_upper, li);
                                if (act_active)
                                    ls_next[act_reg] = ST_STANDBY;
                                ls_next[li] = ST_ACTIVE;
                                act_next    = li;
                            end
                            else
                            begin
                                stat_next = STAT_BAD_LINE;
                            end
                        end
                    end
                end
                CMD_MANUAL:
                begin
                    if (has_code(li))
                    begin
                        wr_next  = 1'b1;
                        mux_next = mux_word(mux_upper, li);
                        if ((act_reg != li) && (ls_reg[act_reg] == ST_ACTIVE))
                            ls_next[act_reg] = lu_reg[act_reg] ? ST_STANDBY : ST_DOWN;
                        act_next    = li;
                        ls_next[li] = ST_ACTIVE;
                    end
                    else
                    begin
                        stat_next = STAT_BAD_LINE;
                    end
                end
                default:
                begin
                    // protected check: switch to better standby or off a down link
                    if (protected_mode && best_found_reg && (best_idx_reg != act_reg)
                        && ((prio_line[best_idx_reg] < prio_line[act_reg])
                            || !lu_reg[act_reg])
                        && has_code(best_idx_reg))
                    begin
                        wr_next               = 1'b1;
                        mux_next              = mux_word(mux_upper, best_idx_reg);
                        ls_next[act_reg]      = lu_reg[act_reg] ? ST_STANDBY : ST_DOWN;
                        act_next              = best_idx_reg;
                        ls_next[best_idx_reg] = ST_ACTIVE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LINES; i++)
            begin
                ls_reg[i] <= ST_DOWN;
                lu_reg[i] <= 1'b0;
            end
            act_reg <= '0;
            mux_reg <= '0;
        end
        else if (dp_cmd.apply)
        begin
            ls_reg  <= ls_next;
            lu_reg  <= lu_next;
            act_reg <= act_next;
            mux_reg <= mux_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.apply)
        begin
            stat_reg <= stat_next;
            wr_reg   <= wr_next;
        end
    end

    always_comb
    begin
        hold_now = 1'b1;
        for (int i = 0; i < NUM_LINES; i++)
            if (ls_reg[i] == ST_ACTIVE)
                hold_now = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.report)
        begin
            status_reg      <= stat_reg;
            active_line_reg <= LINE_W'(act_reg);
            mux_value_reg   <= mux_reg;
            mux_written_reg <= wr_reg;
            holdover_reg    <= hold_now;
            primary_reg     <= (ls_reg[0] == ST_ACTIVE) || (ls_reg[1] == ST_ACTIVE);
        end
    end

    assign status             = status_reg;
    assign active_line        = active_line_reg;
    assign mux_value          = mux_value_reg;
    assign mux_written        = mux_written_reg;
    assign holdover           = holdover_reg;
    assign primary_ref_active = primary_reg;

endmodule

>>> tb/tb_clock_reference_selector.sv
`timescale 1ns / 100ps

module tb_clock_reference_selector;

    import crs_pkg::*;

    localparam int LINES      = NUM_LINES_DEF;
    // Drain tail: long enough for an event to finish, with some slack on top
    localparam int DRAIN_CYC  = LINES + 3 + 8;
    localparam int PHASE_ITEMS = 584;

    // Source code placed in the low three mux bits for each coded line
    localparam logic [2:0] SRC_CODE [0:NUM_CODED-1] = '{3'b000, 3'b001, 3'b100, 3'b010, 3'b011};

    typedef struct packed {
        logic [1:0]        status;
        logic [LINE_W-1:0] active_line;
        logic [7:0]        mux_value;
        logic              mux_written;
        logic              holdover;
        logic              primary_ref_active;
    } selection_t;

    // One entry of stimulus: either a line event or a register write
    typedef struct {
        logic                  is_write;
        logic [1:0]            cmd;
        logic [LINE_W-1:0]     ln;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        int unsigned           idle_pct;
    } line_request_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic [1:0]            cmd       = CMD_CHECK;
    logic [LINE_W-1:0]     line      = '0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PROTECTED;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  busy;
    logic                  cfg_ready;
    logic                  done;
    logic [1:0]            status;
    logic [LINE_W-1:0]     active_line;
    logic [7:0]            mux_value;
    logic                  mux_written;
    logic                  holdover;
    logic                  primary_ref_active;

    line_request_t request_q [$];
    selection_t    selection_q [$];

    // Predictor copy of the selector state and its registers
    logic              sel_protected;
    logic [7:0]        sel_prio [0:NUM_CODED-1];
    logic [4:0]        sel_upper;
    logic [1:0]        sel_state [0:LINES-1];
    logic              sel_link [0:LINES-1];
    logic [LINE_W-1:0] sel_active;
    logic [7:0]        sel_mux;

    int in_flight       = 0;
    int hold_off        = 0;
    int events_sent     = 0;
    int writes_sent     = 0;
    int results_checked = 0;
    int no_source_seen  = 0;
    int bad_line_seen   = 0;
    int rewrites_seen   = 0;
    int mismatches      = 0;

    clock_reference_selector #(
        .NUM_LINES (LINES)
    ) i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .cmd                (cmd),
        .line               (line),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .done               (done),
        .status             (status),
        .active_line        (active_line),
        .mux_value          (mux_value),
        .mux_written        (mux_written),
        .holdover           (holdover),
        .primary_ref_active (primary_ref_active)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Lines without a register behave as priority 255: never picked
    function automatic logic [7:0] prio_of(input logic [LINE_W-1:0] idx);
        return (idx < NUM_CODED) ? sel_prio[idx] : PRIO_NEVER;
    endfunction

    // Lowest priority value among standby lines; ties keep the lower index
    function automatic logic [LINE_W-1:0] best_standby(output logic found);
        logic [LINE_W-1:0] best;
        logic [7:0]        best_p;
        best   = '0;
        best_p = PRIO_NEVER;
        found  = 1'b0;
        for (int i = 0; i < LINES; i++)
        begin
            if (sel_state[i] == ST_STANDBY && prio_of(LINE_W'(i)) < best_p)
            begin
                best   = LINE_W'(i);
                best_p = prio_of(LINE_W'(i));
                found  = 1'b1;
            end
        end
        return best;
    endfunction

    // Rewrite the mux register for a coded line; refuse lines without a code
    function automatic logic switch_mux(input logic [LINE_W-1:0] idx);
        if (idx >= NUM_CODED || idx >= LINES)
            return 1'b0;
        sel_mux = {sel_upper, SRC_CODE[idx]};
        return 1'b1;
    endfunction

    function automatic logic [1:0] released_state(input logic [LINE_W-1:0] idx);
        return sel_link[idx] ? ST_STANDBY : ST_DOWN;
    endfunction

    function automatic selection_t predict_selection(input logic [1:0] c,
                                                     input logic [LINE_W-1:0] ln);
        selection_t        r;
        logic [LINE_W-1:0] act;
        logic [LINE_W-1:0] best;
        logic              found;
        logic [1:0]        st;
        logic              wr;
        logic              any_active;
        act = sel_active;
        st  = STAT_OK;
        wr  = 1'b0;
        if (c != CMD_CHECK && ln >= LINES)
            st = STAT_BAD_LINE;
        else if (c == CMD_LINK_DOWN)
        begin
            sel_link[ln] = 1'b0;
            // Manual mode keeps a failing active line selected; only its link flag drops
            if (!(!sel_protected && act == ln))
            begin
                sel_state[ln] = ST_DOWN;
                if (act == ln)
                begin
                    best = best_standby(found);
                    if (found && best != ln)
                    begin
                        if (switch_mux(best))
                        begin
                            wr              = 1'b1;
                            sel_active      = best;
                            sel_state[best] = ST_ACTIVE;
                        end
                        else
                            st = STAT_BAD_LINE;
                    end
                    else
                        st = STAT_NO_SOURCE;
                end
            end
        end
        else if (c == CMD_LINK_UP)
        begin
            sel_link[ln] = 1'b1;
            if (!sel_protected)
            begin
                if (act != ln)
                    sel_state[ln] = ST_STANDBY;
            end
            else
            begin
                sel_state[ln] = ST_STANDBY;
                if (sel_state[act] != ST_ACTIVE || prio_of(ln) < prio_of(act))
                begin
                    if (switch_mux(ln))
                    begin
                        wr = 1'b1;
                        if (sel_state[act] == ST_ACTIVE)
                            sel_state[act] = ST_STANDBY;
                        sel_state[ln] = ST_ACTIVE;
                        sel_active    = ln;
                    end
                    else
                        st = STAT_BAD_LINE;
                end
            end
        end
        else if (c == CMD_MANUAL)
        begin
            if (switch_mux(ln))
            begin
                wr = 1'b1;
                if (act != ln && sel_state[act] == ST_ACTIVE)
                    sel_state[act] = released_state(act);
                sel_active    = ln;
                sel_state[ln] = ST_ACTIVE;
            end
            else
                st = STAT_BAD_LINE;
        end
        else if (sel_protected)
        begin
            best = best_standby(found);
            if (found && best != act && (prio_of(best) < prio_of(act) || !sel_link[act]))
            begin
                if (switch_mux(best))
                begin
                    wr              = 1'b1;
                    sel_state[act]  = released_state(act);
                    sel_active      = best;
                    sel_state[best] = ST_ACTIVE;
                end
            end
        end
        any_active = 1'b0;
        for (int i = 0; i < LINES; i++)
            if (sel_state[i] == ST_ACTIVE)
                any_active = 1'b1;
        r.status             = st;
        r.active_line        = sel_active;
        r.mux_value          = sel_mux;
        r.mux_written        = wr;
        r.holdover           = !any_active;
        r.primary_ref_active = (sel_state[0] == ST_ACTIVE) || (sel_state[1] == ST_ACTIVE);
        return r;
    endfunction

    task automatic flag_error(input string why, input selection_t exp, input selection_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("ERROR %0t: %s exp st=%0d act=%0d mux=%02h wr=%0b ho=%0b pri=%0b",
                     $time, why, exp.status, exp.active_line, exp.mux_value,
                     exp.mux_written, exp.holdover, exp.primary_ref_active);
            $display("      got st=%0d act=%0d mux=%02h wr=%0b ho=%0b pri=%0b",
                     got.status, got.active_line, got.mux_value, got.mux_written,
                     got.holdover, got.primary_ref_active);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: check results first, then take register writes and new
    // events into the predictor, all from values sampled at the edge
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        selection_t got;
        selection_t exp;
        if (!rst_n)
        begin
            sel_protected = 1'b1;
            sel_upper     = '0;
            sel_active    = '0;
            sel_mux       = '0;
            for (int i = 0; i < NUM_CODED; i++)
                sel_prio[i] = PRIO_NEVER;
            for (int i = 0; i < LINES; i++)
            begin
                sel_state[i] = ST_DOWN;
                sel_link[i]  = 1'b0;
            end
        end
        else
        begin
            if (done)
            begin
                got = {status, active_line, mux_value, mux_written, holdover, primary_ref_active};
                if (selection_q.size() == 0)
                    flag_error("result with nothing outstanding:", 'x, got);
                else
                begin
                    exp = selection_q.pop_front();
                    results_checked++;
                    if (got.status !== exp.status || got.active_line !== exp.active_line ||
                        got.mux_value !== exp.mux_value || got.mux_written !== exp.mux_written ||
                        got.holdover !== exp.holdover ||
                        got.primary_ref_active !== exp.primary_ref_active)
                        flag_error("result differs:", exp, got);
                    if (exp.status == STAT_NO_SOURCE)
                        no_source_seen++;
                    if (exp.status == STAT_BAD_LINE)
                        bad_line_seen++;
                    if (exp.mux_written)
                        rewrites_seen++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                writes_sent++;
                case (cfg_index)
                    CFG_PROTECTED: sel_protected = cfg_data[0];
                    CFG_PRIO_GPSA, CFG_PRIO_GPSB, CFG_PRIO_EXTF, CFG_PRIO_CLKA, CFG_PRIO_CLKB:
                        sel_prio[cfg_index - CFG_PRIO_GPSA] = cfg_data;
                    CFG_MUX_UPPER: sel_upper = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                events_sent++;
                selection_q.push_back(predict_selection(cmd, line));
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: feed events and register writes from the request queue.
    // Hold a write back until every result already transferred has come
    // out, so registers only change while the selector is idle.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic          ev_go;
        logic          wr_go;
        logic          next_start;
        logic          next_write;
        int            flight;
        line_request_t head;
        line_request_t gone;
        if (!rst_n)
        begin
            start     <= 1'b0;
            cfg_valid <= 1'b0;
            in_flight = 0;
            hold_off  = 0;
        end
        else
        begin
            ev_go  = start && !busy;
            wr_go  = cfg_valid && cfg_ready;
            flight = in_flight + (ev_go ? 1 : 0) - (done ? 1 : 0);
            if (ev_go || wr_go)
            begin
                gone = request_q.pop_front();
                // Draw a gap after an event so that the next start lands on a
                // random phase of the selector's work, or after it has gone idle
                if (ev_go && $urandom_range(99) < gone.idle_pct)
                    hold_off = $urandom_range(1, 12);
            end
            next_start = start && !ev_go;
            next_write = cfg_valid && !wr_go;
            if (hold_off > 0)
                hold_off--;
            else if (!next_start && !next_write && request_q.size() > 0)
            begin
                head = request_q[0];
                if (head.is_write)
                begin
                    if (flight == 0)
                    begin
                        next_write = 1'b1;
                        cfg_index <= head.idx;
                        cfg_data  <= head.data;
                    end
                end
                else
                begin
                    next_start = 1'b1;
                    cmd  <= head.cmd;
                    line <= head.ln;
                end
            end
            start     <= next_start;
            cfg_valid <= next_write;
            in_flight = flight;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_event(input logic [1:0] c, input int unsigned ln,
                               input int unsigned pct);
        line_request_t r;
        r.is_write = 1'b0;
        r.cmd      = c;
        r.ln       = LINE_W'(ln);
        r.idx      = CFG_PROTECTED;
        r.data     = '0;
        r.idle_pct = pct;
        request_q.push_back(r);
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        line_request_t r;
        r.is_write = 1'b1;
        r.cmd      = CMD_CHECK;
        r.ln       = '0;
        r.idx      = idx;
        r.data     = CFG_DATA_W'(data);
        r.idle_pct = 0;
        request_q.push_back(r);
    endtask

    // Priorities favour the extremes and close ties over plain random values
    function automatic int unsigned random_prio();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return PRIO_NEVER;
        if (pick <= 4)
            return $urandom_range(3);
        return $urandom_range(255);
    endfunction

    task automatic queue_settings();
        queue_write(CFG_PROTECTED, ($urandom_range(9) < 7) ? 1 : 0);
        queue_write(CFG_PRIO_GPSA, random_prio());
        queue_write(CFG_PRIO_GPSB, random_prio());
        queue_write(CFG_PRIO_EXTF, random_prio());
        queue_write(CFG_PRIO_CLKA, random_prio());
        queue_write(CFG_PRIO_CLKB, random_prio());
        queue_write(CFG_MUX_UPPER, $urandom_range(31));
    endtask

    // Mostly link churn on real lines; checks and a tenth of other events draw any line number, some with no input
    task automatic queue_random_event(input int unsigned pct);
        int unsigned pick;
        logic [1:0]  c;
        int unsigned ln;
        pick = $urandom_range(99);
        if (pick < 30)
            c = CMD_LINK_DOWN;
        else if (pick < 60)
            c = CMD_LINK_UP;
        else if (pick < 75)
            c = CMD_MANUAL;
        else
            c = CMD_CHECK;
        if (c == CMD_CHECK || $urandom_range(9) == 0)
            ln = $urandom_range(7);
        else
            ln = $urandom_range(LINES - 1);
        queue_event(c, ln, pct);
    endtask

    initial
    begin : stimulus
        int unsigned pct;
        int          made;
        int          burst;

        // Directed opening at reset settings: nothing up, all priorities 255
        queue_event(CMD_CHECK, 7, 0);
        queue_event(CMD_LINK_DOWN, 0, 0);      // active line fails with no standby
        queue_event(CMD_LINK_UP, 5, 0);        // lines past the last input
        queue_event(CMD_MANUAL, 6, 0);
        queue_event(CMD_LINK_DOWN, 7, 0);
        queue_event(CMD_LINK_UP, 2, 0);        // nothing active yet, so take it
        queue_write(CFG_MUX_UPPER, 31);
        queue_write(CFG_PRIO_GPSA, 0);
        queue_write(CFG_PRIO_GPSB, 0);
        queue_write(CFG_PRIO_EXTF, 200);
        queue_write(CFG_PRIO_CLKA, 255);
        queue_write(CFG_PRIO_CLKB, 1);
        queue_event(CMD_LINK_UP, 1, 0);        // better than the active line
        queue_event(CMD_LINK_UP, 0, 0);        // tie with active: stay
        queue_event(CMD_LINK_UP, 3, 0);
        queue_event(CMD_LINK_UP, 4, 0);
        queue_event(CMD_LINK_DOWN, 1, 0);      // failover to the best standby
        queue_event(CMD_CHECK, 2, 0);
        queue_event(CMD_MANUAL, 3, 0);         // manual pick while protected
        queue_event(CMD_CHECK, 0, 0);          // revert to the best standby
        queue_write(CFG_PROTECTED, 0);
        queue_event(CMD_LINK_DOWN, 0, 0);      // manual mode: active line stays selected
        queue_event(CMD_CHECK, 4, 0);          // check is a no-op in manual mode
        queue_event(CMD_LINK_UP, 0, 0);
        queue_event(CMD_MANUAL, 4, 0);
        queue_event(CMD_MANUAL, 2, 0);
        queue_event(CMD_MANUAL, 1, 0);
        queue_write(CFG_MUX_UPPER, 0);
        queue_write(CFG_PROTECTED, 1);
        queue_write(CFG_PRIO_GPSA, 255);
        queue_event(CMD_LINK_DOWN, 3, 0);
        queue_event(CMD_MANUAL, 3, 0);         // active line whose link is down
        queue_event(CMD_CHECK, 1, 0);          // so the check moves away from it

        // Random phases: the sender idles often, then more often, then never
        for (int ph = 0; ph < 3; ph++)
        begin
            pct  = (ph == 0) ? 27 : (ph == 1) ? 46 : 0;
            made = 0;
            while (made < PHASE_ITEMS)
            begin
                queue_settings();
                burst = $urandom_range(40, 120);
                for (int k = 0; k < burst && made < PHASE_ITEMS; k++)
                begin
                    queue_random_event(pct);
                    made++;
                end
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every request transferred, every result back, then a short tail
        while (request_q.size() != 0 || start || cfg_valid || selection_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);

        if (selection_q.size() != 0)
            flag_error("expectation left over:", selection_q[0], 'x);

        $display("Covered %0d line events and %0d register writes; %0d results checked.",
                 events_sent, writes_sent, results_checked);
        $display("Of those, %0d rewrote the mux, %0d named a bad line, %0d found no source.",
                 rewrites_seen, bad_line_seen, no_source_seen);
        if (mismatches == 0)
            $display("clock_reference_selector: match");
        else
            $display("clock_reference_selector: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #(4_000_000);
        $display("Watchdog expired with %0d results still outstanding.", selection_q.size());
        $display("clock_reference_selector: mismatch");
        $finish;
    end

endmodule
